FILE: rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// shared types and constants of the integer to ascii formatter
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int POINTER_BITS = 64;
  localparam int MAX_CHARS = 18;
  localparam int NUM_DEC = 10;
  localparam int DD_STAGES = 8;
  localparam int DD_BITS = 4;

  typedef enum logic [2:0] {
    KIND_SDEC = 3'd0,
    KIND_UDEC = 3'd1,
    KIND_HEXL = 3'd2,
    KIND_HEXU = 3'd3,
    KIND_PTR  = 3'd4
  } kind_t;

  typedef logic [7:0] char_t;

  function automatic char_t hex_char(input logic [3:0] d, input logic upper);
    char_t c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else if (upper) begin
      c = 8'h37 + {4'd0, d};
    end else begin
      c = 8'h57 + {4'd0, d};
    end
    return c;
  endfunction

endpackage

FILE: rtl/integer_to_ascii_formatter_unit.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// printf style integer conversion: signed and unsigned decimal, hex, pointer
// ----------------------------------------------------------------------------
// channel | signals                          | dir
// in      | in_valid in_stall kind value     | sink
// out     | out_valid out_stall char_code    | source
//         | position last                    |
// an operand goes through eight double-dabble stages (four bits each), then a
// prepare step loads the emitter, which sends one character per cycle while
// out_stall is low. the input stalls while characters are sent, which holds
// every stage, so nothing is lost. reset clears all valid bits.
module integer_to_ascii_formatter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  char_code,
  output logic [4:0]  position,
  output logic        last
);

  typedef struct packed {
    logic        ok;
    logic [2:0]  kind;
    logic        neg;
    logic [63:0] val;
    logic [31:0] mag;
    logic [39:0] bcd;
  } stage_t;

  stage_t      head;
  logic        head_vld;
  stage_t      tail;
  logic        tail_vld;
  logic        advance;

  logic [7:0]  buf_c [itoa_pkg::MAX_CHARS];
  logic [4:0]  buf_n;
  logic [4:0]  idx;
  logic        busy;

  logic [7:0]  prep_c [itoa_pkg::MAX_CHARS];
  logic [4:0]  prep_n;

  assign advance  = !busy;
  assign in_stall = !advance;

  function automatic logic [39:0] dabble(input logic [39:0] b);
    logic [39:0] r;
    r = b;
    for (int d = 0; d < itoa_pkg::NUM_DEC; d++) begin
      if (r[d*4 +: 4] > 4'd4) begin
        r[d*4 +: 4] = r[d*4 +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  always_comb begin
    logic [31:0] low;
    low = value[31:0];
    head.ok   = (kind <= 3'(itoa_pkg::KIND_PTR));
    head.kind = kind;
    head.neg  = (kind == 3'(itoa_pkg::KIND_SDEC)) && low[31];
    head.val  = value;
    head.mag  = head.neg ? (32'd0 - low) : low;
    head.bcd  = '0;
  end

  assign head_vld = in_valid;

  genvar g;
  generate
    for (g = 0; g < itoa_pkg::DD_STAGES; g++) begin : g_dd
      stage_t d;
      logic   d_vld;
      stage_t nx;
      stage_t q;
      logic   q_vld;
      if (g == 0) begin : g_head
        assign d     = head;
        assign d_vld = head_vld;
      end else begin : g_link
        assign d     = g_dd[g-1].q;
        assign d_vld = g_dd[g-1].q_vld;
      end
      always_comb begin
        logic [39:0] b;
        logic [31:0] m;
        nx = d;
        b = d.bcd;
        m = d.mag;
        for (int k = 0; k < itoa_pkg::DD_BITS; k++) begin
          b = dabble(b);
          b = {b[38:0], m[31]};
          m = {m[30:0], 1'b0};
        end
        nx.bcd = b;
        nx.mag = m;
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          q_vld <= 1'b0;
        end else if (advance) begin
          q_vld <= d_vld;
        end
        if (advance) begin
          q <= nx;
        end
      end
    end
  endgenerate

  assign tail     = g_dd[itoa_pkg::DD_STAGES-1].q;
  assign tail_vld = g_dd[itoa_pkg::DD_STAGES-1].q_vld;

  always_comb begin
    stage_t s;
    logic [4:0] nd;
    logic [4:0] n;
    logic upper;
    logic [63:0] pv;
    s = tail;
    upper = (s.kind == 3'(itoa_pkg::KIND_HEXU));
    pv = s.val;
    for (int i = 0; i < itoa_pkg::MAX_CHARS; i++) begin
      prep_c[i] = 8'h30;
    end
    nd = 5'd1;
    n = 5'd0;
    if (s.kind == 3'(itoa_pkg::KIND_SDEC) || s.kind == 3'(itoa_pkg::KIND_UDEC)) begin
      for (int d = 1; d < itoa_pkg::NUM_DEC; d++) begin
        if (s.bcd[d*4 +: 4] != 4'd0) begin
          nd = 5'(d + 1);
        end
      end
      n = nd + {4'd0, s.neg};
      if (s.neg) begin
        prep_c[0] = 8'h2d;
      end
      for (int i = 0; i < itoa_pkg::NUM_DEC; i++) begin
        if (5'(i) < nd) begin
          prep_c[5'(i) + {4'd0, s.neg}] =
            8'h30 + {4'd0, s.bcd[(nd - 5'(i) - 5'd1)*4 +: 4]};
        end
      end
    end else if (s.kind == 3'(itoa_pkg::KIND_HEXL) || s.kind == 3'(itoa_pkg::KIND_HEXU)) begin
      for (int d = 1; d < 8; d++) begin
        if (s.val[d*4 +: 4] != 4'd0) begin
          nd = 5'(d + 1);
        end
      end
      n = nd;
      for (int i = 0; i < 8; i++) begin
        if (5'(i) < nd) begin
          prep_c[i] = itoa_pkg::hex_char(s.val[(nd - 5'(i) - 5'd1)*4 +: 4], upper);
        end
      end
    end else begin
      if (itoa_pkg::POINTER_BITS < 64) begin
        pv = s.val & ((64'd1 << itoa_pkg::POINTER_BITS) - 64'd1);
      end
      for (int d = 1; d < 16; d++) begin
        if (pv[d*4 +: 4] != 4'd0) begin
          nd = 5'(d + 1);
        end
      end
      n = nd + 5'd2;
      prep_c[1] = 8'h78;
      for (int i = 0; i < 16; i++) begin
        if (5'(i) < nd) begin
          prep_c[i+2] = itoa_pkg::hex_char(pv[(nd - 5'(i) - 5'd1)*4 +: 4], 1'b0);
        end
      end
    end
    prep_n = s.ok ? n : 5'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (!busy) begin
      if (tail_vld && prep_n != 5'd0) begin
        busy <= 1'b1;
        idx  <= '0;
      end
    end else if (!out_stall) begin
      if (idx == buf_n - 5'd1) begin
        busy <= 1'b0;
      end
      idx <= idx + 5'd1;
    end
    if (!busy) begin
      buf_c <= prep_c;
      buf_n <= prep_n;
    end
  end

  assign out_valid = busy;
  assign char_code = buf_c[idx];
  assign position  = idx;
  assign last      = (idx == buf_n - 5'd1);

  a_no_in_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall) else $error("input taken while emitting");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(position)))
    else $error("stalled character moved");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> !out_valid)
    else $error("output continued after last");

endmodule
